FILE: src/hdlc_byte_stuff_framer_macros.svh
// Assertion helpers for the HDLC byte-stuffing framer.
// Each macro expects clk and rst_n in scope.
`ifndef HDLC_BYTE_STUFF_FRAMER_MACROS_SVH
`define HDLC_BYTE_STUFF_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HBSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbsf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HBSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbsf: next-cycle check failed");

`endif

FILE: src/hbsf_pkg.sv
package hbsf_pkg;

  localparam logic [7:0]  FLAG_OCTET = 8'h7E;
  localparam logic [7:0]  ESC_OCTET  = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [7:0]  CTRL_LIMIT = 8'h1F;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Longest burst: a flag and two escaped octets (header or CRC).
  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_END     = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // Line octets caused by one input item, bytes[0] goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic                         closing;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } burst_t;

  // CRC-16, reflected poly, one octet LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  octet);
    logic [15:0] c;
    c = crc_in ^ {8'h00, octet};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] octet);
    return (octet < CTRL_LIMIT) || (octet inside {FLAG_OCTET, ESC_OCTET});
  endfunction

  function automatic burst_t put_raw(input burst_t b, input logic [7:0] octet);
    burst_t r;
    r = b;
    r.bytes[r.count] = octet;
    r.count = r.count + CNT_W'(1);
    return r;
  endfunction

  function automatic burst_t put_escaped(input burst_t b, input logic [7:0] octet);
    burst_t r;
    if (needs_escape(octet)) begin
      r = put_raw(put_raw(b, ESC_OCTET), octet ^ ESC_XOR);
    end else begin
      r = put_raw(b, octet);
    end
    return r;
  endfunction

endpackage

FILE: src/hdlc_byte_stuff_framer.sv
// HDLC-style async transmit framer with byte stuffing and CRC-16 (0xA001).
// Input channel (in_*): one item per transfer; opcode 0 opens a frame with
//   address and control, 1 sends a payload octet, 2 closes the frame with
//   CRC high, CRC low and the closing flag. Payload/end outside a frame and
//   opcode 3 are taken and dropped without output.
// Result channel (out_*): one line octet per transfer; out_run_last marks
//   the last octet caused by an item, out_closing_flag the frame's end flag.
// Path: an accepted item's octets go to the burst buffer, then the output
//   register. The framing state (CRC, frame open) updates at accept.
// Throughput: one octet per cycle while out_stall is low. An item making 1 to 5
//   octets holds in_stall high until its last octet is taken; the next item is taken
//   in the same cycle the last octet of the current one moves to the output register.
// Out stall: the output register holds, the burst buffer holds, and
//   in_stall stays high once the buffer has octets left.
// Reset (rst_n low, synchronous): CRC back to 0xFFFF, no frame open,
//   buffer and output register empty.
module hdlc_byte_stuff_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_address_byte,
  input  logic [7:0] in_control_byte,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_run_last,
  output logic       out_closing_flag
);
  import hbsf_pkg::*;

  burst_t burst;
  logic   accept;
  logic   free;
  logic   load;

  assign in_stall = !free;
  assign accept   = in_valid && !in_stall;
  // dropped items produce an empty burst and load nothing
  assign load     = accept && (burst.count != '0);

  hbsf_frame_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_opcode),
    .address_byte (in_address_byte),
    .control_byte (in_control_byte),
    .payload_byte (in_payload_byte),
    .burst        (burst)
  );

  hbsf_burst_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .burst            (burst),
    .free             (free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_byte    (out_line_byte),
    .out_run_last     (out_run_last),
    .out_closing_flag (out_closing_flag)
  );

endmodule

FILE: src/hbsf_frame_ctl.sv
module hbsf_frame_ctl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [1:0]      opcode,
  input  logic [7:0]      address_byte,
  input  logic [7:0]      control_byte,
  input  logic [7:0]      payload_byte,
  output hbsf_pkg::burst_t burst
);
  import hbsf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic        in_frame_r, in_frame_nxt;

  always_comb begin
    burst        = '0;
    crc_nxt      = crc_r;
    in_frame_nxt = in_frame_r;
    case (opcode_t'(opcode))
      OP_START: begin
        // a start inside a frame simply abandons the old one
        crc_nxt      = crc_byte(crc_byte(CRC_INIT, address_byte), control_byte);
        in_frame_nxt = 1'b1;
        burst        = put_raw(burst, FLAG_OCTET);
        burst        = put_escaped(burst, address_byte);
        burst        = put_escaped(burst, control_byte);
      end
      OP_PAYLOAD: begin
        if (in_frame_r) begin
          crc_nxt = crc_byte(crc_r, payload_byte);
          burst   = put_escaped(burst, payload_byte);
        end
      end
      OP_END: begin
        if (in_frame_r) begin
          crc_nxt       = CRC_INIT;
          in_frame_nxt  = 1'b0;
          burst         = put_escaped(burst, crc_r[15:8]);
          burst         = put_escaped(burst, crc_r[7:0]);
          burst         = put_raw(burst, FLAG_OCTET);
          burst.closing = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      in_frame_r <= 1'b0;
    end else if (accept) begin
      crc_r      <= crc_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

FILE: src/hbsf_burst_out.sv
module hbsf_burst_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  hbsf_pkg::burst_t burst,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_line_byte,
  output logic             out_run_last,
  output logic             out_closing_flag
);
  import hbsf_pkg::*;

  logic [MAX_RESULTS-1:0][7:0] buf_r;
  logic [CNT_W-1:0]            rem_r;
  logic                        close_r;
  logic                        out_valid_r;
  logic [7:0]                  line_r;
  logic                        last_r;
  logic                        closing_r;

  logic out_adv, take, last;

  assign out_adv = !out_valid_r || !out_stall;
  assign take    = (rem_r != '0) && out_adv;
  assign last    = (rem_r == CNT_W'(1));
  assign free    = (rem_r == '0) || (take && last);

  // burst shift buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= burst.count;
    end else if (take) begin
      rem_r <= rem_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r   <= burst.bytes;
      close_r <= burst.closing;
    end else if (take) begin
      buf_r   <= {8'h00, buf_r[MAX_RESULTS-1:1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_adv) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      line_r    <= buf_r[0];
      last_r    <= last;
      closing_r <= last && close_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_byte    = line_r;
  assign out_run_last     = last_r;
  assign out_closing_flag = closing_r;

endmodule

FILE: src/hbsf_checker.sv
`include "hdlc_byte_stuff_framer_macros.svh"

module hbsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic [7:0] in_address_byte,
  input logic [7:0] in_control_byte,
  input logic [7:0] in_payload_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_line_byte,
  input logic       out_run_last,
  input logic       out_closing_flag
);
  import hbsf_pkg::*;

  // stalled input item holds
  `HBSF_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({in_opcode, in_address_byte, in_control_byte, in_payload_byte}))

  // stalled result holds
  `HBSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_line_byte))

  // closing flag is a flag octet and ends its item
  `HBSF_ASSERT_NOW(a_close_flag, out_valid && out_closing_flag,
    (out_line_byte == FLAG_OCTET) && out_run_last)

  // an escape octet is always followed by its partner
  `HBSF_ASSERT_NOW(a_esc_not_last, out_valid && (out_line_byte == ESC_OCTET), !out_run_last)

  // a burst runs without gaps while the receiver takes it
  `HBSF_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && !out_run_last, out_valid)

endmodule

bind hdlc_byte_stuff_framer hbsf_checker u_hbsf_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

import hbsf_pkg::*;

// Tracks the framer state and holds the line octets still owed by the DUT.
class framer_scoreboard;
  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       closing;
  } line_octet_t;

  line_octet_t owed_q[$];
  logic [15:0] crc;
  bit          frame_open;
  int          errors;

  function new();
    crc        = CRC_INIT;
    frame_open = 1'b0;
    errors     = 0;
  endfunction

  function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] octet);
    logic [15:0] c;
    c = acc ^ {8'h00, octet};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function void push_octet(logic [7:0] octet, logic closing);
    line_octet_t e;
    e.octet   = octet;
    e.last    = 1'b0;
    e.closing = closing;
    owed_q.push_back(e);
  endfunction

  function void push_stuffed(logic [7:0] octet);
    if (octet < CTRL_LIMIT || octet == FLAG_OCTET || octet == ESC_OCTET) begin
      push_octet(ESC_OCTET, 1'b0);
      push_octet(octet ^ ESC_XOR, 1'b0);
    end else begin
      push_octet(octet, 1'b0);
    end
  endfunction

  // Called on every input transfer.
  function void note_input(opcode_t op, logic [7:0] addr, logic [7:0] ctrl,
                           logic [7:0] data);
    line_octet_t tail;
    case (op)
      OP_START: begin
        // a start inside a frame simply abandons it
        crc        = crc_step(crc_step(CRC_INIT, addr), ctrl);
        frame_open = 1'b1;
        push_octet(FLAG_OCTET, 1'b0);
        push_stuffed(addr);
        push_stuffed(ctrl);
      end
      OP_PAYLOAD: begin
        if (!frame_open) return;
        crc = crc_step(crc, data);
        push_stuffed(data);
      end
      OP_END: begin
        if (!frame_open) return;
        push_stuffed(crc[15:8]);
        push_stuffed(crc[7:0]);
        push_octet(FLAG_OCTET, 1'b1);
        crc        = CRC_INIT;
        frame_open = 1'b0;
      end
      default: return;
    endcase
    tail      = owed_q.pop_back();
    tail.last = 1'b1;
    owed_q.push_back(tail);
  endfunction

  // Called on every output transfer.
  function void check_result(logic [7:0] octet, logic last, logic closing);
    line_octet_t e;
    if (owed_q.size() == 0) begin
      $error("line_byte: no octet expected, got %02h", octet);
      errors++;
      return;
    end
    e = owed_q.pop_front();
    if (octet !== e.octet) begin
      $error("line_byte: expected %02h, got %02h", e.octet, octet);
      errors++;
    end
    if (last !== e.last) begin
      $error("run_last: expected %0b, got %0b", e.last, last);
      errors++;
    end
    if (closing !== e.closing) begin
      $error("closing_flag: expected %0b, got %0b", e.closing, closing);
      errors++;
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module testbench;
  localparam int RESET_CYCLES = 11;
  localparam int FRAMED_ITEMS = 155;   // items sent inside random frames
  localparam int DRAIN_CYCLES = 20;    // extra cycles after the scoreboard empties
  // watchdog limit on the whole run
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [7:0] EDGE_OCTETS [7] = '{8'h00, 8'h1E, 8'h1F, 8'h20,
                                             8'h7D, 8'h7E, 8'hFF};

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_opcode;
  logic [7:0] in_address_byte;
  logic [7:0] in_control_byte;
  logic [7:0] in_payload_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_line_byte;
  logic       out_run_last;
  logic       out_closing_flag;

  framer_scoreboard sb = new();

  bit quiet;          // when set, neither side idles
  int framed_count;
  int cycle_count;

  hdlc_byte_stuff_framer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_address_byte  (in_address_byte),
    .in_control_byte  (in_control_byte),
    .in_payload_byte  (in_payload_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_byte    (out_line_byte),
    .out_run_last     (out_run_last),
    .out_closing_flag (out_closing_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before a transfer; none during quiet stretches.
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Octet with a bias toward the escape and range boundaries.
  function automatic logic [7:0] pick_octet();
    if ($urandom_range(0, 3) == 0) return EDGE_OCTETS[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  // One input transfer. in_valid stays high when the next item follows
  // with no gap, so it is only lowered when an idle stretch comes first.
  task automatic send_item(opcode_t op, logic [7:0] addr, logic [7:0] ctrl,
                           logic [7:0] data);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_address_byte <= addr;
    in_control_byte <= ctrl;
    in_payload_byte <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_payload(logic [7:0] data);
    send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), data);
  endtask

  task automatic send_end();
    send_item(OP_END, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Receiver: random stall (possibly none) before every output transfer.
  initial begin
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor: values read here are the ones from just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(opcode_t'(in_opcode), in_address_byte, in_control_byte,
                      in_payload_byte);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_line_byte, out_run_last, out_closing_flag);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n_data;
    cycle_count     = 0;
    framed_count    = 0;
    quiet           = 1'b0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_UNUSED;
    in_address_byte <= 8'h00;
    in_control_byte <= 8'h00;
    in_payload_byte <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // stray items before any frame: all dropped
    send_payload(8'hA5);
    send_end();
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    // header with lowest and highest octet
    send_item(OP_START, 8'h00, 8'hFF, 8'h00);
    // escape boundaries: 0x1E escaped, 0x1F and 0x20 not
    send_payload(8'h7E);
    send_payload(8'h7D);
    send_payload(8'h1E);
    send_payload(8'h1F);
    send_payload(8'h20);
    send_payload(8'h80);
    send_payload(8'hFF);
    send_item(OP_UNUSED, 8'h00, 8'h00, 8'h00);   // ignored inside a frame
    send_end();
    // longest burst: flag plus two escaped header octets
    send_item(OP_START, 8'h7E, 8'h7D, 8'h00);
    send_payload(8'h00);
    // restart inside an open frame, CRC starts over
    send_item(OP_START, 8'h1F, 8'h1E, 8'h55);
    send_payload(8'h01);
    send_end();
    // after close, stray items are dropped again
    send_end();
    send_payload(8'h42);

    // --- random: mostly well-formed frames, some noise and abandoned frames ---
    while (framed_count < FRAMED_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(opcode_t'($urandom_range(OP_PAYLOAD, OP_UNUSED)),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_item(OP_START, pick_octet(), pick_octet(), 8'($urandom));
        n_data = $urandom_range(0, 6);
        repeat (n_data) send_payload(pick_octet());
        framed_count += n_data + 1;
        if ($urandom_range(0, 7) != 0) begin
          send_end();
          framed_count++;
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
